// ===== hdl/e2q_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Euler XYZ to unit quaternion block.
// No dependencies; every other file refers to this package by scoped names.
package e2q_pkg;

	localparam int ANGLE_W = 16;
	localparam int QUAT_W = 16;
	localparam int TRIG_W = 34;
	localparam int CORDIC_STEPS = 30;
	localparam int HALF_SHIFT = 33 - ANGLE_W;
	localparam int FRAC_W = QUAT_W - 2;
	localparam int QUOT_W = QUAT_W - 1;
	localparam int NORM2_W = 64;
	localparam int NORM_W = 32;
	localparam int SQRT_STEPS = NORM2_W / 2;
	localparam int NUM_W = TRIG_W + FRAC_W;
	localparam int PROD_W = 2 * TRIG_W;

	localparam logic signed [TRIG_W-1:0] Q30_PI = 34'sd3373259426;
	localparam logic signed [TRIG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [TRIG_W-1:0] Q30_INV_GAIN = 34'sd652032874;
	localparam logic signed [PROD_W-1:0] Q30_ROUND = PROD_W'(64'sd536870912);
	localparam logic [QUOT_W-1:0] QUAT_ONE = QUOT_W'(1) << FRAC_W;
	localparam logic [NORM_W-1:0] NORM_MIN = NORM_W'(2);

	localparam logic signed [TRIG_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
		34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
		34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536,
		34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
		34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
		34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
	};

	typedef struct packed {
		logic signed [TRIG_W-1:0] w;
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic signed [TRIG_W-1:0] z;
	} quat_t;

	typedef struct packed {
		logic valid;
		logic neg;
		logic tiny;
	} div_ctl_t;

	function automatic logic signed [TRIG_W-1:0] mul_q30(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		p = p + Q30_ROUND;
		return p[TRIG_W+29:30];
	endfunction

endpackage

// ===== hdl/e2q_cordic.sv =====
// Half-angle sine and cosine: range reduction then one CORDIC rotation per pipeline stage.
// Depends on e2q_pkg.
module e2q_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
	output logic                                out_valid,
	output logic signed [e2q_pkg::TRIG_W-1:0]   out_sin,
	output logic signed [e2q_pkg::TRIG_W-1:0]   out_cos
);

	localparam int N = e2q_pkg::CORDIC_STEPS;
	localparam int W = e2q_pkg::TRIG_W;

	logic signed [W-1:0] h;
	logic signed [W-1:0] h_red;
	logic                flip;

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic signed [W-1:0] z_s [0:N];
	logic                f_s [0:N];
	logic                v_s [0:N];

	always_comb begin
		h = {{(W-e2q_pkg::ANGLE_W){angle[e2q_pkg::ANGLE_W-1]}}, angle} <<< e2q_pkg::HALF_SHIFT;
		flip = 1'b0;
		h_red = h;
		if (h > e2q_pkg::Q30_HALF_PI) begin
			h_red = h - e2q_pkg::Q30_PI;
			flip = 1'b1;
		end else if (h < -e2q_pkg::Q30_HALF_PI) begin
			h_red = h + e2q_pkg::Q30_PI;
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= e2q_pkg::Q30_INV_GAIN;
			y_s[0] <= '0;
			z_s[0] <= h_red;
			f_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i+1] <= f_s[i];
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - e2q_pkg::ATAN_Q30[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + e2q_pkg::ATAN_Q30[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sin <= f_s[N] ? -y_s[N] : y_s[N];
			out_cos <= f_s[N] ? -x_s[N] : x_s[N];
		end
	end

endmodule

// ===== hdl/e2q_qmul.sv =====
// Two chained Hamilton products, qz * (qy * qx), in Q30 over three stages.
// Depends on e2q_pkg.
module e2q_qmul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic signed [e2q_pkg::TRIG_W-1:0]  sx,
	input  logic signed [e2q_pkg::TRIG_W-1:0]  cx,
	input  logic signed [e2q_pkg::TRIG_W-1:0]  sy,
	input  logic signed [e2q_pkg::TRIG_W-1:0]  cy,
	input  logic signed [e2q_pkg::TRIG_W-1:0]  sz,
	input  logic signed [e2q_pkg::TRIG_W-1:0]  cz,
	output logic                               out_valid,
	output e2q_pkg::quat_t                     out_quat
);

	e2q_pkg::quat_t a_s1;
	logic signed [e2q_pkg::TRIG_W-1:0] sz_s1, cz_s1;
	logic signed [e2q_pkg::TRIG_W-1:0] p_s2 [8];
	logic v_s1, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1.w <= e2q_pkg::mul_q30(cy, cx);
			a_s1.x <= e2q_pkg::mul_q30(cy, sx);
			a_s1.y <= e2q_pkg::mul_q30(sy, cx);
			a_s1.z <= e2q_pkg::mul_q30(-sy, sx);
			sz_s1 <= sz;
			cz_s1 <= cz;

			p_s2[0] <= e2q_pkg::mul_q30(cz_s1, a_s1.w);
			p_s2[1] <= e2q_pkg::mul_q30(sz_s1, a_s1.z);
			p_s2[2] <= e2q_pkg::mul_q30(cz_s1, a_s1.x);
			p_s2[3] <= e2q_pkg::mul_q30(sz_s1, a_s1.y);
			p_s2[4] <= e2q_pkg::mul_q30(cz_s1, a_s1.y);
			p_s2[5] <= e2q_pkg::mul_q30(sz_s1, a_s1.x);
			p_s2[6] <= e2q_pkg::mul_q30(cz_s1, a_s1.z);
			p_s2[7] <= e2q_pkg::mul_q30(sz_s1, a_s1.w);

			out_quat.w <= p_s2[0] - p_s2[1];
			out_quat.x <= p_s2[2] - p_s2[3];
			out_quat.y <= p_s2[4] + p_s2[5];
			out_quat.z <= p_s2[6] + p_s2[7];
		end
	end

endmodule

// ===== hdl/e2q_norm.sv =====
// Sum of squares and a pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on e2q_pkg; carries the quaternion alongside the norm.
module e2q_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  e2q_pkg::quat_t                    in_quat,
	output logic                              out_valid,
	output e2q_pkg::quat_t                    out_quat,
	output logic [e2q_pkg::NORM_W-1:0]        out_norm
);

	localparam int N = e2q_pkg::SQRT_STEPS;
	localparam int NW = e2q_pkg::NORM2_W;
	localparam int PW = e2q_pkg::PROD_W;

	logic [NW-1:0] sq_s1 [4];
	e2q_pkg::quat_t q_s1;
	logic v_s1;

	logic [NW-1:0] n_s [0:N];
	logic [NW-1:0] r_s [0:N];
	e2q_pkg::quat_t q_s [0:N];
	logic v_s [0:N];

	function automatic logic [NW-1:0] square(input logic signed [e2q_pkg::TRIG_W-1:0] a);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(a);
		return p[NW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1[0] <= square(in_quat.x);
			sq_s1[1] <= square(in_quat.y);
			sq_s1[2] <= square(in_quat.z);
			sq_s1[3] <= square(in_quat.w);
			q_s1 <= in_quat;
			n_s[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2] + sq_s1[3];
			r_s[0] <= '0;
			q_s[0] <= q_s1;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_root
		localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1] <= q_s[k];
				if (n_s[k] >= r_s[k] + BIT) begin
					n_s[k+1] <= n_s[k] - (r_s[k] + BIT);
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1] <= n_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_quat = q_s[N];
	assign out_norm = r_s[N][e2q_pkg::NORM_W-1:0];

endmodule

// ===== hdl/e2q_div.sv =====
// One restoring-division lane: rounded numerator over the norm, one quotient bit per stage.
// Depends on e2q_pkg; side bits travel with the data.
module e2q_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  e2q_pkg::div_ctl_t                 in_ctl,
	input  logic [e2q_pkg::NUM_W-1:0]         numer,
	input  logic [e2q_pkg::NORM_W-1:0]        norm,
	output e2q_pkg::div_ctl_t                 out_ctl,
	output logic [e2q_pkg::QUOT_W-1:0]        quot
);

	localparam int N = e2q_pkg::QUOT_W;
	localparam int W = e2q_pkg::NUM_W;

	logic [W-1:0] rem_s [0:N];
	logic [e2q_pkg::NORM_W-1:0] d_s [0:N];
	logic [N-1:0] q_s [0:N];
	e2q_pkg::div_ctl_t c_s [0:N];

	assign rem_s[0] = numer;
	assign d_s[0] = norm;
	assign q_s[0] = '0;
	assign c_s[0] = in_ctl;

	for (genvar k = 0; k < N; k++) begin : g_bit
		logic [W-1:0] dsh;
		assign dsh = W'(d_s[k]) << (N - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_s[k+1] <= '0;
			end else if (en) begin
				c_s[k+1] <= c_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= d_s[k];
				if (rem_s[k] >= dsh) begin
					rem_s[k+1] <= rem_s[k] - dsh;
					q_s[k+1] <= {q_s[k][N-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1] <= {q_s[k][N-2:0], 1'b0};
				end
			end
		end
	end

	assign out_ctl = c_s[N];
	assign quot = q_s[N];

endmodule

// ===== hdl/euler_xyz_to_unit_quaternion_top.sv =====
// Euler XYZ angles to unit quaternion, top level.
// Channels: input beat carries angle_x, angle_y, angle_z (signed Q4.12 radians),
// accepted when in_valid is high and in_stall is low. Output beat carries
// quat_x, quat_y, quat_z, quat_w (signed Q1.14, q = qz*qy*qx), taken when
// out_valid is high and out_stall is low.
// Throughput: one beat per cycle while the output is not stalled.
// The pipeline holds the 30 CORDIC stages, 32 square-root stages and 15 divider
// stages, plus 9 more registers for range reduction, sign restore, products,
// squares, the sum of squares, rounding and the output register.
// A norm below 2 in Q30 gives the identity (0, 0, 0, 1.0).
// Reset clears all valid bits; no beat is in flight afterward.
// When out_valid is high and out_stall is high, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Depends on e2q_pkg, e2q_cordic, e2q_qmul, e2q_norm, e2q_div.
module euler_xyz_to_unit_quaternion_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle_x,
	input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle_y,
	input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [e2q_pkg::QUAT_W-1:0]   quat_x,
	output logic signed [e2q_pkg::QUAT_W-1:0]   quat_y,
	output logic signed [e2q_pkg::QUAT_W-1:0]   quat_z,
	output logic signed [e2q_pkg::QUAT_W-1:0]   quat_w
);

	localparam int QW = e2q_pkg::QUAT_W;
	localparam int TW = e2q_pkg::TRIG_W;
	localparam int NUMW = e2q_pkg::NUM_W;

	logic en;
	logic vx, vy, vz;
	logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
	logic vm;
	e2q_pkg::quat_t qm;
	logic vn;
	e2q_pkg::quat_t qn;
	logic [e2q_pkg::NORM_W-1:0] norm;

	logic signed [TW-1:0] comp [4];
	logic [NUMW-1:0] numer [4];
	logic [NUMW-1:0] numer_s1 [4];
	logic [e2q_pkg::NORM_W-1:0] norm_s1;
	e2q_pkg::div_ctl_t ctl_s1 [4];
	e2q_pkg::div_ctl_t ctl_d [4];
	logic [e2q_pkg::QUOT_W-1:0] quot [4];
	logic signed [QW-1:0] res [4];

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	e2q_cordic u_cx (.clk, .arst_n, .en, .in_valid, .angle(angle_x),
		.out_valid(vx), .out_sin(sx), .out_cos(cx));
	e2q_cordic u_cy (.clk, .arst_n, .en, .in_valid, .angle(angle_y),
		.out_valid(vy), .out_sin(sy), .out_cos(cy));
	e2q_cordic u_cz (.clk, .arst_n, .en, .in_valid, .angle(angle_z),
		.out_valid(vz), .out_sin(sz), .out_cos(cz));

	e2q_qmul u_qmul (.clk, .arst_n, .en, .in_valid(vx & vy & vz),
		.sx, .cx, .sy, .cy, .sz, .cz, .out_valid(vm), .out_quat(qm));

	e2q_norm u_norm (.clk, .arst_n, .en, .in_valid(vm), .in_quat(qm),
		.out_valid(vn), .out_quat(qn), .out_norm(norm));

	assign comp[0] = qn.x;
	assign comp[1] = qn.y;
	assign comp[2] = qn.z;
	assign comp[3] = qn.w;

	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic [TW-1:0] mag;
		assign mag = comp[j][TW-1] ? TW'(-comp[j]) : TW'(comp[j]);
		assign numer[j] = (NUMW'(mag) << e2q_pkg::FRAC_W) + NUMW'(norm >> 1);

		always_ff @(posedge clk) begin
			if (en) begin
				numer_s1[j] <= numer[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s1[j] <= '0;
			end else if (en) begin
				ctl_s1[j] <= '{valid: vn, neg: comp[j][TW-1],
					tiny: norm < e2q_pkg::NORM_MIN};
			end
		end

		e2q_div u_div (.clk, .arst_n, .en, .in_ctl(ctl_s1[j]), .numer(numer_s1[j]),
			.norm(norm_s1), .out_ctl(ctl_d[j]), .quot(quot[j]));

		logic [e2q_pkg::QUOT_W-1:0] qc;
		always_comb begin
			qc = (quot[j] > e2q_pkg::QUAT_ONE) ? e2q_pkg::QUAT_ONE : quot[j];
			res[j] = ctl_d[j].neg ? -QW'(qc) : QW'(qc);
			if (ctl_d[j].tiny) begin
				res[j] = (j == 3) ? QW'(e2q_pkg::QUAT_ONE) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s1 <= norm;
			quat_x <= res[0];
			quat_y <= res[1];
			quat_z <= res[2];
			quat_w <= res[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_d[0].valid & ctl_d[1].valid & ctl_d[2].valid & ctl_d[3].valid;
		end
	end

endmodule

// ===== test/euler_xyz_to_unit_quaternion_top_tb.sv =====
// Testbench for euler_xyz_to_unit_quaternion_top: drives angle triples with random gaps and
// output stalls, predicts each unit quaternion in plain integer math and checks every beat.
// Depends on the RTL top level and e2q_pkg.
module euler_xyz_to_unit_quaternion_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = e2q_pkg::ANGLE_W;
	localparam int QW = e2q_pkg::QUAT_W;
	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 200;
	localparam int LONG_HOLD = 400;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint INV_GAIN_Q30 = 64'sd652032874;
	localparam longint ARCTAN_Q30 [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	typedef struct {
		logic signed [AW-1:0] ax;
		logic signed [AW-1:0] ay;
		logic signed [AW-1:0] az;
	} angles_t;

	typedef struct {
		logic signed [QW-1:0] qx;
		logic signed [QW-1:0] qy;
		logic signed [QW-1:0] qz;
		logic signed [QW-1:0] qw;
	} unit_quat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [AW-1:0] angle_x = '0;
	logic signed [AW-1:0] angle_y = '0;
	logic signed [AW-1:0] angle_z = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;

	angles_t pending_angles[$];
	unit_quat_t expected_quats[$];
	int total_items = 0;
	int beats_in = 0;
	int beats_out = 0;
	int errors = 0;
	int cycles = 0;
	logic in_taken = 0;
	logic out_taken = 0;
	int send_gap = 0;
	int recv_hold = 0;
	int burst_left = 0;
	logic long_hold_done = 0;

	euler_xyz_to_unit_quaternion_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
	);

	task automatic half_sin_cos(input logic signed [AW-1:0] ang,
		output longint s, output longint c);
		longint h, x, y, z, dx, dy;
		logic flip;
		h = longint'(ang) * (longint'(1) << (33 - AW));
		flip = 0;
		if (h > HALF_PI_Q30) begin
			h -= PI_Q30;
			flip = 1;
		end else if (h < -HALF_PI_Q30) begin
			h += PI_Q30;
			flip = 1;
		end
		x = INV_GAIN_Q30;
		y = 0;
		z = h;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN_Q30[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN_Q30[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint mul30(input longint a, input longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [QW-1:0] scale_to_unit(input longint c,
		input longint unsigned norm);
		longint unsigned mag, q, one;
		mag = c < 0 ? -c : c;
		one = longint'(1) << (QW - 2);
		q = ((mag << (QW - 2)) + norm / 2) / norm;
		if (q > one)
			q = one;
		return c < 0 ? -QW'(q) : QW'(q);
	endfunction

	task automatic predict_quat(input angles_t a, output unit_quat_t r);
		longint sx, cx, sy, cy, sz, cz, pw, px, py, pz, w, x, y, z;
		longint unsigned n2, norm;
		half_sin_cos(a.ax, sx, cx);
		half_sin_cos(a.ay, sy, cy);
		half_sin_cos(a.az, sz, cz);
		pw = mul30(cy, cx);
		px = mul30(cy, sx);
		py = mul30(sy, cx);
		pz = mul30(-sy, sx);
		w = mul30(cz, pw) - mul30(sz, pz);
		x = mul30(cz, px) - mul30(sz, py);
		y = mul30(cz, py) + mul30(sz, px);
		z = mul30(cz, pz) + mul30(sz, pw);
		n2 = x * x + y * y + z * z + w * w;
		norm = int_sqrt(n2);
		if (norm < 2) begin
			r = '{qx: '0, qy: '0, qz: '0, qw: QW'(1) << (QW - 2)};
		end else begin
			r.qx = scale_to_unit(x, norm);
			r.qy = scale_to_unit(y, norm);
			r.qz = scale_to_unit(z, norm);
			r.qw = scale_to_unit(w, norm);
		end
	endtask

	function automatic logic signed [AW-1:0] pick_angle();
		logic signed [AW-1:0] edges [10] = '{
			-32768, 32767, 0, 12867, 12868, -12867, -12868, 25735, -25736, 1
		};
		case ($urandom_range(0, 3))
			0: return edges[$urandom_range(0, 9)] + AW'($urandom_range(0, 4)) - AW'(2);
			1: return AW'($urandom_range(0, 6000)) - AW'(3000);
			default: return AW'($urandom);
		endcase
	endfunction

	task automatic add_item(input int x, input int y, input int z);
		angles_t a;
		a = '{ax: AW'(x), ay: AW'(y), az: AW'(z)};
		pending_angles.insert(pending_angles.size(), a);
		total_items++;
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// Sample both handshakes; predict each input beat, check each output beat.
	always @(posedge clk) begin
		unit_quat_t e, p;
		cycles <= cycles + 1;
		in_taken <= in_valid && !in_stall;
		out_taken <= out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall) begin
			predict_quat('{ax: angle_x, ay: angle_y, az: angle_z}, p);
			expected_quats.insert(expected_quats.size(), p);
			beats_in <= beats_in + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			beats_out <= beats_out + 1;
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected beat expected none actual (%0d %0d %0d %0d)",
					$time, quat_x, quat_y, quat_z, quat_w);
				errors <= errors + 1;
			end else begin
				e = expected_quats.pop_front();
				if (e.qx !== quat_x || e.qy !== quat_y || e.qz !== quat_z ||
					e.qw !== quat_w) begin
					$display("%0t: mismatch expected (%0d %0d %0d %0d) actual (%0d %0d %0d %0d)",
						$time, e.qx, e.qy, e.qz, e.qw, quat_x, quat_y, quat_z, quat_w);
					errors <= errors + 1;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sender: hold until taken, then wait a drawn gap before the next beat, or none inside an occasional burst.
	always @(negedge clk) begin
		angles_t a;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (pending_angles.size() > 0) begin
				a = pending_angles.pop_front();
				angle_x <= a.ax;
				angle_y <= a.ay;
				angle_z <= a.az;
				in_valid <= 1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
					send_gap <= 0;
				end else begin
					send_gap <= $urandom_range(0, 16);
					if ($urandom_range(0, 15) == 0)
						burst_left <= $urandom_range(10, 40);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Receiver: stall a drawn count after most beats; one long hold mid-run.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && beats_out >= 100) begin
				long_hold_done <= 1;
				recv_hold <= LONG_HOLD;
				out_stall <= 1;
			end else if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_stall <= 1;
			end else if (out_taken && !out_stall) begin
				if ($urandom_range(0, 2) == 0) begin
					recv_hold <= 0;
					out_stall <= 0;
				end else begin
					recv_hold <= $urandom_range(0, 15);
					out_stall <= 1;
				end
			end else begin
				out_stall <= 0;
			end
		end
	end

	initial begin
		add_item(0, 0, 0);
		add_item(-32768, -32768, -32768);
		add_item(32767, 32767, 32767);
		add_item(32767, 0, 0);
		add_item(0, -32768, 0);
		add_item(0, 0, 32767);
		add_item(12867, 12868, -12867);
		add_item(-12868, 12867, 12868);
		add_item(25735, -25736, 25736);
		add_item(6434, 0, 0);
		add_item(0, 6434, 0);
		add_item(0, 0, 6434);
		add_item(12868, 12868, 12868);
		add_item(-12868, -12868, -12868);
		add_item(1, -1, 1);
		add_item(21845, -21846, 10922);
		add_item(-32768, 32767, 0);
		add_item(16'h5555, 16'hAAAA, 16'h7FFF);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_item(pick_angle(), pick_angle(), pick_angle());
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (beats_in == total_items && expected_quats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
